// ----- src/drmt_pkg.sv -----
// shared types, constants and command codes of the dirty rectangle merge table
package drmt_pkg;

    localparam int CAPACITY  = 16;
    localparam int W_COORD   = 15;
    localparam int W_IN      = 16;
    localparam int W_CNT_OUT = 5;
    localparam int W_PADDR   = 3;
    localparam int W_PDATA   = 32;

    localparam logic [W_COORD-1:0] SCREEN_WIDTH_RST  = 15'd640;
    localparam logic [W_COORD-1:0] SCREEN_HEIGHT_RST = 15'd480;

    // register index, taken from paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DUMP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLIP,
        S_SCAN,
        S_CMP,
        S_MVRD,
        S_MVWR,
        S_APPEND,
        S_STAT,
        S_DRD,
        S_DOUT
    } t_state;

    // stored as edges; width and height are rebuilt on read-out
    typedef struct packed {
        logic [W_COORD-1:0] left;
        logic [W_COORD-1:0] top;
        logic [W_COORD-1:0] right;
        logic [W_COORD-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic load;
        logic clip;
        logic idx_clr;
        logic idx_inc;
        logic rd_cnt;
        logic merge;
        logic move;
        logic append;
        logic clear;
        logic emit_rect;
        logic emit_stat;
    } t_dp_cmd;

    typedef struct packed {
        logic drop;
        logic at_end;
        logic touch;
        logic empty;
        logic dump_last;
    } t_dp_stat;

endpackage

// ----- src/drmt_ram.sv -----
// generic single write, single read ram with registered read data
module drmt_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/drmt_regs.sv -----
// apb configuration registers: screen width and height
module drmt_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [drmt_pkg::W_PADDR-1:0]        paddr,
    input  logic [drmt_pkg::W_PDATA-1:0]        pwdata,
    output logic [drmt_pkg::W_PDATA-1:0]        prdata,
    output logic                                pready,
    output logic [drmt_pkg::W_COORD-1:0]        o_screen_width,
    output logic [drmt_pkg::W_COORD-1:0]        o_screen_height
);

    logic [drmt_pkg::W_COORD-1:0] r_width;
    logic [drmt_pkg::W_COORD-1:0] r_height;
    logic                         s_wr;
    logic                         s_sel;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite;
    assign s_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= drmt_pkg::SCREEN_WIDTH_RST;
            r_height <= drmt_pkg::SCREEN_HEIGHT_RST;
        end else if (s_wr) begin
            if (s_sel == drmt_pkg::REG_SCREEN_WIDTH) begin
                r_width <= pwdata[drmt_pkg::W_COORD-1:0];
            end else begin
                r_height <= pwdata[drmt_pkg::W_COORD-1:0];
            end
        end
    end

    always_comb begin
        if (s_sel == drmt_pkg::REG_SCREEN_HEIGHT) begin
            prdata = drmt_pkg::W_PDATA'(r_height);
        end else begin
            prdata = drmt_pkg::W_PDATA'(r_width);
        end
    end

    assign o_screen_width  = r_width;
    assign o_screen_height = r_height;

endmodule

// ----- src/drmt_ctrl.sv -----
// controller state machine: sequences add, clear and dump commands
module drmt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_cmd,
    input  drmt_pkg::t_dp_stat i_stat,
    output drmt_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    drmt_pkg::t_state r_state;
    drmt_pkg::t_state n_state;
    drmt_pkg::t_cmd   s_cmd;

    assign s_cmd = drmt_pkg::t_cmd'(i_cmd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            drmt_pkg::S_IDLE: begin
                if (i_start) begin
                    case (s_cmd)
                        drmt_pkg::CMD_ADD:   n_state = drmt_pkg::S_CLIP;
                        drmt_pkg::CMD_DUMP:  n_state = i_stat.empty ? drmt_pkg::S_STAT
                                                                    : drmt_pkg::S_DRD;
                        default:             n_state = drmt_pkg::S_STAT;
                    endcase
                end
            end
            drmt_pkg::S_CLIP:   n_state = i_stat.drop ? drmt_pkg::S_STAT : drmt_pkg::S_SCAN;
            drmt_pkg::S_SCAN:   n_state = i_stat.at_end ? drmt_pkg::S_APPEND : drmt_pkg::S_CMP;
            drmt_pkg::S_CMP:    n_state = i_stat.touch ? drmt_pkg::S_MVRD : drmt_pkg::S_SCAN;
            drmt_pkg::S_MVRD:   n_state = drmt_pkg::S_MVWR;
            drmt_pkg::S_MVWR:   n_state = drmt_pkg::S_SCAN;
            drmt_pkg::S_APPEND: n_state = drmt_pkg::S_STAT;
            drmt_pkg::S_STAT:   n_state = drmt_pkg::S_IDLE;
            drmt_pkg::S_DRD:    n_state = drmt_pkg::S_DOUT;
            drmt_pkg::S_DOUT:   n_state = i_stat.dump_last ? drmt_pkg::S_IDLE : drmt_pkg::S_DRD;
            default:            n_state = drmt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            drmt_pkg::S_IDLE: begin
                o_cmd.load    = i_start;
                o_cmd.idx_clr = i_start;
                o_cmd.clear   = i_start && (s_cmd == drmt_pkg::CMD_CLEAR);
            end
            drmt_pkg::S_CLIP: begin
                o_cmd.clip    = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            drmt_pkg::S_CMP: begin
                o_cmd.merge   = i_stat.touch;
                o_cmd.idx_inc = !i_stat.touch;
            end
            drmt_pkg::S_MVRD:   o_cmd.rd_cnt = 1'b1;
            drmt_pkg::S_MVWR:   o_cmd.move   = 1'b1;
            drmt_pkg::S_APPEND: o_cmd.append = 1'b1;
            drmt_pkg::S_STAT:   o_cmd.emit_stat = 1'b1;
            drmt_pkg::S_DOUT: begin
                o_cmd.emit_rect = 1'b1;
                o_cmd.idx_inc   = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != drmt_pkg::S_IDLE);

endmodule

// ----- src/drmt_dp.sv -----
// datapath: clipping, touch test, union, table counters and result registers
module drmt_dp #(
    parameter int CAPACITY = drmt_pkg::CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  drmt_pkg::t_dp_cmd               i_cmd,
    output drmt_pkg::t_dp_stat              o_stat,
    input  logic [drmt_pkg::W_COORD-1:0]    i_screen_width,
    input  logic [drmt_pkg::W_COORD-1:0]    i_screen_height,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_left,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_top,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_wide,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_tall,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_left,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_top,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_wide,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_tall,
    output logic                            o_rect_valid,
    output logic [drmt_pkg::W_CNT_OUT-1:0]  o_entry_count,
    output logic                            o_table_full,
    output logic                            o_last,
    output logic                            o_valid
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = drmt_pkg::W_IN + 2;
    localparam int RW = 4 * drmt_pkg::W_COORD;

    logic signed [drmt_pkg::W_IN-1:0] r_x, r_y, r_w, r_h;
    drmt_pkg::t_rect                  r_cur;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    r_idx;
    logic                             r_full;

    logic [drmt_pkg::W_COORD-1:0]     r_o_left, r_o_top, r_o_wide, r_o_tall;
    logic                             r_o_rv, r_o_last, r_o_full, r_o_valid;
    logic [drmt_pkg::W_CNT_OUT-1:0]   r_o_count;

    logic signed [SW-1:0] s_x, s_y, s_w, s_h, s_r, s_b, s_l, s_t, s_rc, s_bc, s_sw, s_sh;
    drmt_pkg::t_rect      s_rd;
    drmt_pkg::t_rect      s_uni;
    logic [RW-1:0]        s_rdata;
    logic                 s_cnt_full;
    logic                 s_we;
    logic [IW-1:0]        s_waddr;
    logic [RW-1:0]        s_wdata;
    logic [IW-1:0]        s_raddr;

    // clip the incoming rectangle to the screen
    assign s_x  = SW'(r_x);
    assign s_y  = SW'(r_y);
    assign s_w  = SW'(r_w);
    assign s_h  = SW'(r_h);
    assign s_sw = signed'(SW'(i_screen_width));
    assign s_sh = signed'(SW'(i_screen_height));
    assign s_r  = s_x + s_w;
    assign s_b  = s_y + s_h;
    assign s_l  = (s_x < 0) ? '0 : s_x;
    assign s_t  = (s_y < 0) ? '0 : s_y;
    assign s_rc = (s_r > s_sw) ? s_sw : s_r;
    assign s_bc = (s_b > s_sh) ? s_sh : s_b;

    assign s_rd       = drmt_pkg::t_rect'(s_rdata);
    assign s_cnt_full = (r_count == CW'(CAPACITY));

    // closed comparisons: touching edges merge too
    assign o_stat.touch = (s_rd.left <= r_cur.right) && (r_cur.left <= s_rd.right) &&
                          (s_rd.top <= r_cur.bottom) && (r_cur.top <= s_rd.bottom);
    assign o_stat.drop  = r_full || (s_w <= 0) || (s_h <= 0) ||
                          (s_rc <= s_l) || (s_bc <= s_t);
    assign o_stat.at_end    = (r_idx == r_count);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.dump_last = ((CW + 1)'(r_idx) + 1'b1) == (CW + 1)'(r_count);

    always_comb begin
        s_uni.left   = (s_rd.left < r_cur.left) ? s_rd.left : r_cur.left;
        s_uni.top    = (s_rd.top < r_cur.top) ? s_rd.top : r_cur.top;
        s_uni.right  = (s_rd.right > r_cur.right) ? s_rd.right : r_cur.right;
        s_uni.bottom = (s_rd.bottom > r_cur.bottom) ? s_rd.bottom : r_cur.bottom;
    end

    // move copies the last entry into the merged slot
    assign s_raddr = i_cmd.rd_cnt ? r_count[IW-1:0] : r_idx[IW-1:0];
    assign s_we    = i_cmd.move || (i_cmd.append && !s_cnt_full);
    assign s_waddr = i_cmd.move ? r_idx[IW-1:0] : r_count[IW-1:0];
    assign s_wdata = i_cmd.move ? s_rdata : RW'(r_cur);

    drmt_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= signed'(i_rect_left);
            r_y <= signed'(i_rect_top);
            r_w <= signed'(i_rect_wide);
            r_h <= signed'(i_rect_tall);
        end
        if (i_cmd.clip) begin
            r_cur.left   <= s_l[drmt_pkg::W_COORD-1:0];
            r_cur.top    <= s_t[drmt_pkg::W_COORD-1:0];
            r_cur.right  <= s_rc[drmt_pkg::W_COORD-1:0];
            r_cur.bottom <= s_bc[drmt_pkg::W_COORD-1:0];
        end else if (i_cmd.merge) begin
            r_cur <= s_uni;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_full  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.idx_clr || i_cmd.move) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_full  <= 1'b0;
            end else if (i_cmd.merge) begin
                r_count <= r_count - 1'b1;
            end else if (i_cmd.append) begin
                if (s_cnt_full) begin
                    r_count <= '0;
                    r_full  <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // result beat registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit_rect || i_cmd.emit_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rect) begin
            r_o_left  <= s_rd.left;
            r_o_top   <= s_rd.top;
            r_o_wide  <= s_rd.right - s_rd.left;
            r_o_tall  <= s_rd.bottom - s_rd.top;
            r_o_rv    <= 1'b1;
            r_o_last  <= o_stat.dump_last;
            r_o_count <= drmt_pkg::W_CNT_OUT'(r_count);
            r_o_full  <= r_full;
        end else if (i_cmd.emit_stat) begin
            r_o_left  <= '0;
            r_o_top   <= '0;
            r_o_wide  <= '0;
            r_o_tall  <= '0;
            r_o_rv    <= 1'b0;
            r_o_last  <= 1'b1;
            r_o_count <= drmt_pkg::W_CNT_OUT'(r_count);
            r_o_full  <= r_full;
        end
    end

    assign o_out_left    = r_o_left;
    assign o_out_top     = r_o_top;
    assign o_out_wide    = r_o_wide;
    assign o_out_tall    = r_o_tall;
    assign o_rect_valid  = r_o_rv;
    assign o_entry_count = r_o_count;
    assign o_table_full  = r_o_full;
    assign o_last        = r_o_last;
    assign o_valid       = r_o_valid;

endmodule

// ----- src/dirty_rect_merge_table.sv -----
// Dirty rectangle table. A command beat is taken when start is high and busy is low. Add clips
// the rectangle, then walks the stored table (one ram read per entry compared); each merge
// adds a move (a read of the last entry, then its write into the merged slot) and restarts
// the walk from entry 0. An add that is ignored or clipped away goes straight to the status
// beat, as do clear, unused codes and a dump of an empty table; a dump gives one beat per
// stored entry. Results leave on o_valid in the cycle after they are formed, at most one beat
// per cycle (a dump reads the ram before each beat); the receiver cannot stall them and every
// beat must be taken in its cycle. o_last marks the final beat of a command.
// Busy drops while the last beat is on the outputs, so the next command can be accepted then.
module dirty_rect_merge_table #(
    parameter int CAPACITY = drmt_pkg::CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_cmd,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_left,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_top,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_wide,
    input  logic [drmt_pkg::W_IN-1:0]       i_rect_tall,
    output logic                            o_valid,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_left,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_top,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_wide,
    output logic [drmt_pkg::W_COORD-1:0]    o_out_tall,
    output logic                            o_rect_valid,
    output logic [drmt_pkg::W_CNT_OUT-1:0]  o_entry_count,
    output logic                            o_table_full,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [drmt_pkg::W_PADDR-1:0]    paddr,
    input  logic [drmt_pkg::W_PDATA-1:0]    pwdata,
    output logic [drmt_pkg::W_PDATA-1:0]    prdata,
    output logic                            pready
);

    drmt_pkg::t_dp_cmd            s_cmd;
    drmt_pkg::t_dp_stat           s_stat;
    logic [drmt_pkg::W_COORD-1:0] s_screen_width;
    logic [drmt_pkg::W_COORD-1:0] s_screen_height;

    drmt_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_screen_width  (s_screen_width),
        .o_screen_height (s_screen_height)
    );

    drmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd),
        .o_busy  (busy)
    );

    drmt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_stat          (s_stat),
        .i_screen_width  (s_screen_width),
        .i_screen_height (s_screen_height),
        .i_rect_left     (i_rect_left),
        .i_rect_top      (i_rect_top),
        .i_rect_wide     (i_rect_wide),
        .i_rect_tall     (i_rect_tall),
        .o_out_left      (o_out_left),
        .o_out_top       (o_out_top),
        .o_out_wide      (o_out_wide),
        .o_out_tall      (o_out_tall),
        .o_rect_valid    (o_rect_valid),
        .o_entry_count   (o_entry_count),
        .o_table_full    (o_table_full),
        .o_last          (o_last),
        .o_valid         (o_valid)
    );

endmodule
